// ----- src/smap_pkg.sv -----
// ----------------------------------------------------------------------------
// smap_pkg
// Shared types and constants for the STUN mapped-address parser.
// ----------------------------------------------------------------------------
package smap_pkg;

  localparam int POSITION_BITS = 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] ATTR_START = POSITION_BITS'(20);
  localparam logic [POSITION_BITS-1:0] MIN_HEADER = POSITION_BITS'(8);

  localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;
  localparam logic [15:0] XMA_TYPE = 16'h0020;
  localparam logic [7:0] FAMILY_IPV4 = 8'h01;

  localparam int SIZE_BITS = 16;
  localparam int END_BITS = SIZE_BITS + 2;

  localparam int DATA_BITS = 8;
  localparam int RESULT_BITS = 56;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_NOT_STUN   = 2'd0,
    ST_NO_ADDRESS = 2'd1,
    ST_UNCHANGED  = 2'd2,
    ST_NEW        = 2'd3
  } smap_status_t;

  typedef struct packed {
    logic        header_ok;
    logic        found;
    logic [15:0] port_x;
    logic [31:0] addr_x;
  } smap_summary_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = STUN_COOKIE[31:24];
      2'd1:    b = STUN_COOKIE[23:16];
      2'd2:    b = STUN_COOKIE[15:8];
      default: b = STUN_COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- src/smap_front.sv -----
// ----------------------------------------------------------------------------
// smap_front
// Byte-level parser: checks the cookie, walks attributes, captures the
// XORed port and address, and hands one summary per datagram to the queue.
// ----------------------------------------------------------------------------
module smap_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [smap_pkg::DATA_BITS-1:0] data_byte,
  input  logic                          last_byte,
  output logic                          push,
  output smap_pkg::smap_summary_t       summary
);
  import smap_pkg::*;

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic                     cookie_ok, cookie_ok_next;
  logic [POSITION_BITS-1:0] attr_begin, attr_begin_next;
  logic [15:0]              attr_kind, attr_kind_next;
  logic [SIZE_BITS-1:0]     attr_size, attr_size_next;
  logic [7:0]               family, family_next;
  logic                     found, found_next;
  logic [15:0]              cport, cport_next;
  logic [31:0]              caddr, caddr_next;

  always_comb begin
    logic [POSITION_BITS-1:0] off;
    logic [END_BITS-1:0]      attr_end;
    logic                     near;
    pos_next        = pos;
    cookie_ok_next  = cookie_ok;
    attr_begin_next = attr_begin;
    attr_kind_next  = attr_kind;
    attr_size_next  = attr_size;
    family_next     = family;
    found_next      = found;
    cport_next      = cport;
    caddr_next      = caddr;
    push            = 1'b0;
    near            = 1'b0;
    off             = pos - attr_begin;
    attr_end        = ((END_BITS'(attr_size) + END_BITS'(3)) & ~END_BITS'(3)) + END_BITS'(4);
    if (in_fire) begin
      if (pos != POS_MAX) begin
        if (pos >= POSITION_BITS'(4) && pos <= POSITION_BITS'(7) &&
            data_byte != cookie_byte(pos[1:0])) begin
          cookie_ok_next = 1'b0;
        end
        if (pos >= ATTR_START && pos >= attr_begin && !found) begin
          if (off >= POSITION_BITS'(4) && END_BITS'(off) == attr_end) begin
            attr_begin_next = pos;
            off = '0;
          end
          near = (off < POSITION_BITS'(12));
          if (near) begin
            case (off[3:0])
              4'd0: attr_kind_next = {data_byte, 8'h00};
              4'd1: attr_kind_next = {attr_kind[15:8], data_byte};
              4'd2: attr_size_next = {data_byte, 8'h00};
              4'd3: attr_size_next = {attr_size[15:8], data_byte};
              4'd5: family_next = data_byte;
              4'd6, 4'd7: cport_next = {cport[7:0], data_byte};
              4'd8, 4'd9, 4'd10: caddr_next = {caddr[23:0], data_byte};
              4'd11: begin
                caddr_next = {caddr[23:0], data_byte};
                if (attr_kind == XMA_TYPE && family == FAMILY_IPV4) begin
                  found_next = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        pos_next = pos + POSITION_BITS'(1);
      end
      if (last_byte) begin
        push = 1'b1;
      end
    end
    summary.header_ok = cookie_ok_next && (pos_next >= MIN_HEADER);
    summary.found     = found_next;
    summary.port_x    = cport_next;
    summary.addr_x    = caddr_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos        <= '0;
      cookie_ok  <= 1'b1;
      attr_begin <= ATTR_START;
      attr_kind  <= '0;
      attr_size  <= '0;
      family     <= '0;
      found      <= 1'b0;
      cport      <= '0;
      caddr      <= '0;
    end else begin
      pos        <= pos_next;
      cookie_ok  <= cookie_ok_next;
      attr_begin <= attr_begin_next;
      attr_kind  <= attr_kind_next;
      attr_size  <= attr_size_next;
      family     <= family_next;
      found      <= found_next;
      cport      <= cport_next;
      caddr      <= caddr_next;
    end
  end

endmodule

// ----- src/smap_queue.sv -----
// ----------------------------------------------------------------------------
// smap_queue
// Short FIFO of datagram summaries between the parser and the result stage.
// ----------------------------------------------------------------------------
module smap_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  smap_pkg::smap_summary_t wr_data,
  input  logic                    pop,
  output smap_pkg::smap_summary_t rd_data,
  output logic                    full,
  output logic                    empty
);
  import smap_pkg::*;

  smap_summary_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0]  count;

  assign full    = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/smap_back.sv -----
// ----------------------------------------------------------------------------
// smap_back
// Result stage: un-XORs the captured fields, updates the stored public
// address, and holds one result in the output register.
// ----------------------------------------------------------------------------
module smap_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  smap_pkg::smap_summary_t           rd_data,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [smap_pkg::RESULT_BITS-1:0] m_tdata
);
  import smap_pkg::*;

  logic [15:0]  public_port;
  logic [31:0]  public_addr;
  smap_status_t status, status_next;
  logic [15:0]  port_out, port_next;
  logic [31:0]  addr_out, addr_next;
  logic         update;

  assign pop = !empty && (!m_tvalid || m_tready);

  always_comb begin
    logic [15:0] port_d;
    logic [31:0] addr_d;
    port_d      = rd_data.port_x ^ STUN_COOKIE[31:16];
    addr_d      = rd_data.addr_x ^ STUN_COOKIE;
    update      = 1'b0;
    port_next   = '0;
    addr_next   = '0;
    if (!rd_data.header_ok) begin
      status_next = ST_NOT_STUN;
    end else if (!rd_data.found) begin
      status_next = ST_NO_ADDRESS;
    end else begin
      port_next = port_d;
      addr_next = addr_d;
      if (port_d != public_port || addr_d != public_addr) begin
        status_next = ST_NEW;
        update      = 1'b1;
      end else begin
        status_next = ST_UNCHANGED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      public_port <= '0;
      public_addr <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        if (update) begin
          public_port <= port_next;
          public_addr <= addr_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status   <= status_next;
      port_out <= port_next;
      addr_out <= addr_next;
    end
  end

  assign m_tdata = {6'b0, addr_out, port_out, status};

endmodule

// ----- src/stun_mapped_address_parser.sv -----
// ----------------------------------------------------------------------------
// stun_mapped_address_parser
// Parses a STUN response byte stream and reports the XOR-MAPPED-ADDRESS.
// The summary is queued with the last byte, then registered as the result.
// Throughput: one byte per cycle; the parser stalls only while the
// two-entry summary queue is full behind a stalled result.
// Reset returns the parser to its start state, empties the queue, drops the
// result valid flag and clears the stored public address to zero.
// ----------------------------------------------------------------------------
module stun_mapped_address_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [smap_pkg::DATA_BITS-1:0]   s_tdata,   // data_byte[7:0]
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [smap_pkg::RESULT_BITS-1:0] m_tdata    // status[1:0], mapped_port[17:2],
                                                      // mapped_address[49:18], zero
);
  import smap_pkg::*;

  logic          in_fire;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  smap_summary_t wr_data;
  smap_summary_t rd_data;

  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;

  smap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .push      (push),
    .summary   (wr_data)
  );

  smap_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (full),
    .empty   (empty)
  );

  smap_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .rd_data  (rd_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
